/* rtl/core/sioc_pkg.sv */
// shared types and constants for the sphere insertion overlap checker
package sioc_pkg;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;
  localparam int StreakBits  = 32;
  localparam int PipeDepth   = 3;
  localparam int DrainBits   = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_PERIODIC = 3'd0,
    CFG_LEN_X    = 3'd1,
    CFG_LEN_Y    = 3'd2,
    CFG_LEN_Z    = 3'd3,
    CFG_PAD      = 3'd4,
    CFG_SEP      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_ACCEPT  = 2'd0,
    OUT_WALL    = 2'd1,
    OUT_OVERLAP = 2'd2,
    OUT_FULL    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/sioc_cell.sv */
// one store cell of the rotating sphere ring
module sioc_cell #(
  parameter int COORD_BITS  = 24,
  parameter int RADIUS_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic                   load_i,
  input  logic [COORD_BITS-1:0]  nxt_x_i,
  input  logic [COORD_BITS-1:0]  nxt_y_i,
  input  logic [COORD_BITS-1:0]  nxt_z_i,
  input  logic [RADIUS_BITS-1:0] nxt_r_i,
  input  logic [COORD_BITS-1:0]  ld_x_i,
  input  logic [COORD_BITS-1:0]  ld_y_i,
  input  logic [COORD_BITS-1:0]  ld_z_i,
  input  logic [RADIUS_BITS-1:0] ld_r_i,
  output logic [COORD_BITS-1:0]  x_o,
  output logic [COORD_BITS-1:0]  y_o,
  output logic [COORD_BITS-1:0]  z_o,
  output logic [RADIUS_BITS-1:0] r_o
);

  logic [COORD_BITS-1:0]  x_q, y_q, z_q;
  logic [RADIUS_BITS-1:0] r_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= ld_x_i;
      y_q <= ld_y_i;
      z_q <= ld_z_i;
      r_q <= ld_r_i;
    end else if (shift_i) begin
      x_q <= nxt_x_i;
      y_q <= nxt_y_i;
      z_q <= nxt_z_i;
      r_q <= nxt_r_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign r_o = r_q;

endmodule

/* rtl/core/sioc_dist.sv */
// three stage distance compare between the probe and the ring head entry
module sioc_dist #(
  parameter int COORD_BITS  = 24,
  parameter int RADIUS_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic                   periodic_i,
  input  logic [COORD_BITS-1:0]  len_i   [3],
  input  logic [RADIUS_BITS-1:0] sep_i,
  input  logic [COORD_BITS-1:0]  probe_i [3],
  input  logic [RADIUS_BITS-1:0] probe_r_i,
  input  logic [COORD_BITS-1:0]  ent_i   [3],
  input  logic [RADIUS_BITS-1:0] ent_r_i,
  output logic                   hit_o
);

  localparam int DW  = COORD_BITS + 2;
  localparam int MW  = COORD_BITS + 1;
  localparam int SQW = 2 * MW;
  localparam int SUW = SQW + 2;
  localparam int RQW = RADIUS_BITS + 2;
  localparam int RSW = 2 * RQW;
  localparam int CW  = (SUW > RSW) ? SUW : RSW;

  logic [MW-1:0]  mag   [3];
  logic [MW-1:0]  mag_q [3];
  logic [SQW-1:0] sq_q  [3];
  logic [RQW-1:0] req_q;
  logic [RSW-1:0] reqsq_q;
  logic           v1_q, v2_q, hit_q;
  logic [SUW-1:0] sum;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [DW-1:0] d, dm, lsig;
    logic signed [DW:0]   d2, lx;
    always_comb begin
      d    = $signed({2'b00, probe_i[a]}) - $signed({2'b00, ent_i[a]});
      lsig = $signed({2'b00, len_i[a]});
      d2   = {d, 1'b0};
      lx   = $signed({3'b000, len_i[a]});
      dm   = d;
      if (periodic_i && (d2 > lx)) begin
        dm = d - lsig;
      end else if (periodic_i && (d2 < -lx)) begin
        dm = d + lsig;
      end
      mag[a] = dm[DW-1] ? MW'(-dm) : MW'(dm);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag;
    req_q <= RQW'(probe_r_i) + RQW'(ent_r_i) + RQW'(sep_i);
    for (int a = 0; a < 3; a++) begin
      sq_q[a] <= mag_q[a] * mag_q[a];
    end
    reqsq_q <= req_q * req_q;
  end

  assign sum = SUW'(sq_q[0]) + SUW'(sq_q[1]) + SUW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      hit_q <= v2_q && (CW'(sum) < CW'(reqsq_q));
    end
  end

  assign hit_o = hit_q;

endmodule

/* rtl/core/sphere_insertion_overlap_checker_top.sv */
// top level of the sphere insertion overlap checker
// Each proposed sphere is first checked against the walls (hard wall mode), then the
// store of accepted spheres rotates once through a ring of MAX_SPHERES cells past a
// single pipelined distance unit, one entry per cycle. An item that fails the wall
// check skips the scan and goes straight to its result; the scan length follows the
// ring length, and the next item can be taken in the cycle the result is presented.
// One item is worked on at a time; a new item is taken while the previous result
// waits in the output register. Configuration is written through a valid/ready port
// that is always ready.
module sphere_insertion_overlap_checker_top #(
  parameter int MAX_SPHERES = 1024,
  parameter int COORD_BITS  = 24,
  parameter int RADIUS_BITS = 20
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sioc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [sioc_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [COORD_BITS-1:0]            center_x_i,
  input  logic [COORD_BITS-1:0]            center_y_i,
  input  logic [COORD_BITS-1:0]            center_z_i,
  input  logic [RADIUS_BITS-1:0]           sphere_radius_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             accepted_o,
  output logic [1:0]                       outcome_o,
  output logic [$clog2(MAX_SPHERES)-1:0]   stored_index_o,
  output logic [$clog2(MAX_SPHERES+1)-1:0] sphere_total_o,
  output logic [sioc_pkg::StreakBits-1:0]  reject_streak_o
);

  localparam int IDX_BITS = $clog2(MAX_SPHERES);
  localparam int CNT_BITS = $clog2(MAX_SPHERES + 1);
  localparam int EW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  sioc_pkg::state_e state_q, state_d;

  logic                   periodic_q;
  logic [COORD_BITS-1:0]  len_q [3];
  logic [RADIUS_BITS-1:0] pad_q, sep_q;

  logic [COORD_BITS-1:0]  probe_q [3];
  logic [RADIUS_BITS-1:0] pr_q;
  logic                   wall_fail_q, overlap_q;
  logic [IDX_BITS-1:0]    k_q;
  logic [sioc_pkg::DrainBits-1:0] drain_q;
  logic [CNT_BITS-1:0]    count_q;
  logic [sioc_pkg::StreakBits-1:0] streak_q;

  logic                   out_valid_q, acc_q;
  logic [1:0]             outc_q;
  logic [IDX_BITS-1:0]    sidx_q;

  logic in_xfer, fire, shift, hit, cmp_valid, wall_fail, accept;
  sioc_pkg::outcome_e outc;
  logic [COORD_BITS-1:0] cin [3];
  logic [COORD_BITS-1:0] wrapped [3];

  logic [COORD_BITS-1:0]  ring_x [MAX_SPHERES];
  logic [COORD_BITS-1:0]  ring_y [MAX_SPHERES];
  logic [COORD_BITS-1:0]  ring_z [MAX_SPHERES];
  logic [RADIUS_BITS-1:0] ring_r [MAX_SPHERES];
  logic [COORD_BITS-1:0]  head   [3];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != sioc_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign fire        = (state_q == sioc_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);
  assign shift       = (state_q == sioc_pkg::ST_SCAN);
  assign cmp_valid   = shift && (CNT_BITS'(k_q) < count_q);

  assign cin[0] = center_x_i;
  assign cin[1] = center_y_i;
  assign cin[2] = center_z_i;

  // wall check on the incoming item
  always_comb begin
    logic [EW-1:0] eff;
    eff       = EW'(sphere_radius_i) + EW'(pad_q);
    wall_fail = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if ((EW'(cin[a]) < eff) || ((EW'(cin[a]) + eff) > EW'(len_q[a]))) begin
        wall_fail = 1'b1;
      end
    end
    if (periodic_q) begin
      wall_fail = 1'b0;
    end
  end

  always_comb begin
    if (wall_fail_q) begin
      outc = sioc_pkg::OUT_WALL;
    end else if (overlap_q) begin
      outc = sioc_pkg::OUT_OVERLAP;
    end else if (count_q == CNT_BITS'(MAX_SPHERES)) begin
      outc = sioc_pkg::OUT_FULL;
    end else begin
      outc = sioc_pkg::OUT_ACCEPT;
    end
    accept = (outc == sioc_pkg::OUT_ACCEPT);
    for (int a = 0; a < 3; a++) begin
      wrapped[a] = (periodic_q && (probe_q[a] >= len_q[a])) ? probe_q[a] - len_q[a]
                                                            : probe_q[a];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sioc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = wall_fail ? sioc_pkg::ST_DONE : sioc_pkg::ST_SCAN;
        end
      end
      sioc_pkg::ST_SCAN: begin
        if (k_q == IDX_BITS'(MAX_SPHERES - 1)) begin
          state_d = sioc_pkg::ST_DRAIN;
        end
      end
      sioc_pkg::ST_DRAIN: begin
        if (drain_q == sioc_pkg::DrainBits'(sioc_pkg::PipeDepth - 1)) begin
          state_d = sioc_pkg::ST_DONE;
        end
      end
      sioc_pkg::ST_DONE: begin
        if (fire) begin
          state_d = sioc_pkg::ST_IDLE;
        end
      end
      default: state_d = sioc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sioc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
      len_q[0]   <= '1;
      len_q[1]   <= '1;
      len_q[2]   <= '1;
      pad_q      <= '0;
      sep_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sioc_pkg::CFG_PERIODIC: periodic_q <= cfg_data_i[0];
        sioc_pkg::CFG_LEN_X:    len_q[0]   <= cfg_data_i[COORD_BITS-1:0];
        sioc_pkg::CFG_LEN_Y:    len_q[1]   <= cfg_data_i[COORD_BITS-1:0];
        sioc_pkg::CFG_LEN_Z:    len_q[2]   <= cfg_data_i[COORD_BITS-1:0];
        sioc_pkg::CFG_PAD:      pad_q      <= cfg_data_i[RADIUS_BITS-1:0];
        sioc_pkg::CFG_SEP:      sep_q      <= cfg_data_i[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      probe_q <= cin;
      pr_q    <= sphere_radius_i;
    end
    if (fire) begin
      acc_q  <= accept;
      outc_q <= outc;
      sidx_q <= accept ? count_q[IDX_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_fail_q <= 1'b0;
      overlap_q   <= 1'b0;
      k_q         <= '0;
      drain_q     <= '0;
      count_q     <= '0;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        wall_fail_q <= wall_fail;
        overlap_q   <= 1'b0;
        k_q         <= '0;
        drain_q     <= '0;
      end else begin
        if (hit) begin
          overlap_q <= 1'b1;
        end
        if (shift) begin
          k_q <= k_q + 1'b1;
        end
        if (state_q == sioc_pkg::ST_DRAIN) begin
          drain_q <= drain_q + 1'b1;
        end
      end
      if (fire) begin
        if (accept) begin
          count_q  <= count_q + 1'b1;
          streak_q <= '0;
        end else if (streak_q != '1) begin
          streak_q <= streak_q + 1'b1;
        end
      end
      out_valid_q <= fire ? 1'b1 : (out_valid_q && out_stall_i);
    end
  end

  // rotating store, head at cell zero
  for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_SPHERES;
    sioc_cell #(
      .COORD_BITS (COORD_BITS),
      .RADIUS_BITS(RADIUS_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .load_i (fire && accept && (count_q[IDX_BITS-1:0] == IDX_BITS'(i))),
      .nxt_x_i(ring_x[NXT]),
      .nxt_y_i(ring_y[NXT]),
      .nxt_z_i(ring_z[NXT]),
      .nxt_r_i(ring_r[NXT]),
      .ld_x_i (wrapped[0]),
      .ld_y_i (wrapped[1]),
      .ld_z_i (wrapped[2]),
      .ld_r_i (pr_q),
      .x_o    (ring_x[i]),
      .y_o    (ring_y[i]),
      .z_o    (ring_z[i]),
      .r_o    (ring_r[i])
    );
  end

  assign head[0] = ring_x[0];
  assign head[1] = ring_y[0];
  assign head[2] = ring_z[0];

  sioc_dist #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cmp_valid),
    .periodic_i(periodic_q),
    .len_i     (len_q),
    .sep_i     (sep_q),
    .probe_i   (probe_q),
    .probe_r_i (pr_q),
    .ent_i     (head),
    .ent_r_i   (ring_r[0]),
    .hit_o     (hit)
  );

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign outcome_o       = outc_q;
  assign stored_index_o  = sidx_q;
  assign sphere_total_o  = count_q;
  assign reject_streak_o = streak_q;

endmodule

/* rtl/core/sioc_checker.sv */
// port level checks for the sphere insertion overlap checker
module sioc_checker #(
  parameter int MAX_SPHERES = 1024
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             accepted_o,
  input logic [1:0]                       outcome_o,
  input logic [$clog2(MAX_SPHERES)-1:0]   stored_index_o,
  input logic [sioc_pkg::StreakBits-1:0]  reject_streak_o
);

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_acc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (outcome_o == sioc_pkg::OUT_ACCEPT)))
    else $error("accepted flag disagrees with outcome");

  a_rej_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (stored_index_o == '0))
    else $error("rejected sphere shows a slot");

  a_streak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (reject_streak_o == '0))
    else $error("streak not cleared on accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(outcome_o)))
    else $error("stalled result changed");

endmodule

bind sphere_insertion_overlap_checker_top sioc_checker #(
  .MAX_SPHERES(MAX_SPHERES)
) u_sioc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .accepted_o     (accepted_o),
  .outcome_o      (outcome_o),
  .stored_index_o (stored_index_o),
  .reject_streak_o(reject_streak_o)
);

/* sim/tb_top.sv */
// self-checking testbench for the sphere insertion overlap checker top level
`timescale 1ns / 100ps

module tb_top;

  localparam int NSLOT     = 1024;
  localparam int IDX_W     = $clog2(NSLOT);
  localparam int TOT_W     = $clog2(NSLOT + 1);
  localparam int LIMIT     = 5000;
  localparam int MAX_ERRS  = 10;
  localparam longint COORD_MAX = 64'hFF_FFFF;
  localparam longint RAD_MAX   = 64'hF_FFFF;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [19:0] r;
  } sphere_t;

  typedef struct {
    logic               acc;
    sioc_pkg::outcome_e oc;
    logic [IDX_W-1:0]   idx;
    logic [TOT_W-1:0]   tot;
    logic [31:0]        streak;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sioc_pkg::CfgIdxBits-1:0] cfg_index_i = '0;
  logic [sioc_pkg::CfgDataBits-1:0] cfg_data_i = '0;
  logic in_valid_i;
  logic in_stall_o;
  logic [23:0] center_x_i, center_y_i, center_z_i;
  logic [19:0] sphere_radius_i;
  logic out_valid_o;
  logic out_stall_i;
  logic accepted_o;
  logic [1:0] outcome_o;
  logic [IDX_W-1:0] stored_index_o;
  logic [TOT_W-1:0] sphere_total_o;
  logic [31:0] reject_streak_o;

  sphere_insertion_overlap_checker_top #(
    .MAX_SPHERES(NSLOT),
    .COORD_BITS (24),
    .RADIUS_BITS(20)
  ) u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .center_x_i, .center_y_i, .center_z_i, .sphere_radius_i,
    .out_valid_o, .out_stall_i, .accepted_o, .outcome_o, .stored_index_o,
    .sphere_total_o, .reject_streak_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the block state
  bit          periodic;
  longint      dom_len [3];
  longint      pad_len;
  longint      sep_len;
  logic [23:0] pack_x [NSLOT];
  logic [23:0] pack_y [NSLOT];
  logic [23:0] pack_z [NSLOT];
  logic [19:0] pack_r [NSLOT];
  int          packed_count;
  logic [31:0] streak_run;

  sphere_t  proposals [$];
  verdict_t verdicts [$];
  int       errors;
  int       idle_cycles;

  function automatic void add_proposal(sphere_t s);
    proposals = {proposals, s};
  endfunction

  function automatic void add_verdict(verdict_t v);
    verdicts = {verdicts, v};
  endfunction

  function automatic bit fits_axis(longint c, longint l, longint eff);
    return (c >= eff) && (c <= l - eff);
  endfunction

  function automatic longint axis_gap_sq(longint a, longint b, longint l, bit per);
    longint d;
    d = a - b;
    if (per) begin
      if (2 * d > l) d = d - l;
      else if (2 * d < -l) d = d + l;
    end
    return d * d;
  endfunction

  function automatic longint wrap_coord(longint c, longint l);
    return (c >= l) ? c - l : c;
  endfunction

  function automatic verdict_t judge_sphere(sphere_t s);
    verdict_t           v;
    longint             eff, req, gap_sq;
    sioc_pkg::outcome_e oc;
    oc = sioc_pkg::OUT_ACCEPT;
    if (!periodic) begin
      eff = longint'(s.r) + pad_len;
      if (!fits_axis(s.x, dom_len[0], eff) || !fits_axis(s.y, dom_len[1], eff) ||
          !fits_axis(s.z, dom_len[2], eff)) oc = sioc_pkg::OUT_WALL;
    end
    if (oc == sioc_pkg::OUT_ACCEPT) begin
      for (int i = 0; i < packed_count; i++) begin
        req    = longint'(s.r) + longint'(pack_r[i]) + sep_len;
        gap_sq = axis_gap_sq(s.x, pack_x[i], dom_len[0], periodic) +
                 axis_gap_sq(s.y, pack_y[i], dom_len[1], periodic) +
                 axis_gap_sq(s.z, pack_z[i], dom_len[2], periodic);
        if (gap_sq < req * req) begin
          oc = sioc_pkg::OUT_OVERLAP;
          break;
        end
      end
    end
    if (oc == sioc_pkg::OUT_ACCEPT && packed_count >= NSLOT) oc = sioc_pkg::OUT_FULL;
    v.idx = '0;
    if (oc == sioc_pkg::OUT_ACCEPT) begin
      v.idx = IDX_W'(packed_count);
      pack_x[packed_count] = periodic ? 24'(wrap_coord(s.x, dom_len[0])) : s.x;
      pack_y[packed_count] = periodic ? 24'(wrap_coord(s.y, dom_len[1])) : s.y;
      pack_z[packed_count] = periodic ? 24'(wrap_coord(s.z, dom_len[2])) : s.z;
      pack_r[packed_count] = s.r;
      packed_count++;
      streak_run = '0;
    end else if (streak_run != 32'hFFFF_FFFF) begin
      streak_run++;
    end
    v.acc    = (oc == sioc_pkg::OUT_ACCEPT);
    v.oc     = oc;
    v.tot    = TOT_W'(packed_count);
    v.streak = streak_run;
    return v;
  endfunction

  function automatic longint pick_radius();
    return ($urandom_range(0, 3) == 0) ? longint'($urandom & 32'hF_FFFF)
                                       : longint'($urandom_range(0, 4095));
  endfunction

  function automatic longint pick_coord(int ax);
    longint l;
    l = (dom_len[ax] > COORD_MAX) ? COORD_MAX : dom_len[ax];
    return ($urandom_range(0, 7) == 0) ? longint'($urandom & 32'hFF_FFFF)
                                       : longint'($urandom % (l + 1));
  endfunction

  function automatic sphere_t draw_sphere();
    sphere_t s;
    int      kind, j, ax;
    longint  r, reach, eff, c[3];
    kind = $urandom_range(0, 9);
    r = pick_radius();
    for (int a = 0; a < 3; a++) c[a] = pick_coord(a);
    if (kind < 2) begin
      for (int a = 0; a < 3; a++) c[a] = longint'($urandom & 32'hFF_FFFF);
      r = longint'($urandom & 32'hF_FFFF);
    end else if (kind < 6 && packed_count > 0) begin
      j = $urandom_range(0, packed_count - 1);
      reach = r + pack_r[j] + sep_len + 1;
      c[0] = pack_x[j] + longint'($urandom % (2 * reach + 1)) - reach;
      c[1] = pack_y[j] + longint'($urandom % (2 * reach + 1)) - reach;
      c[2] = pack_z[j] + longint'($urandom % (2 * reach + 1)) - reach;
    end else if (kind < 8) begin
      ax  = $urandom_range(0, 2);
      eff = r + pad_len;
      c[ax] = ($urandom_range(0, 1) ? eff : dom_len[ax] - eff) + $urandom_range(0, 2) - 1;
    end
    s.x = 24'(c[0]);
    s.y = 24'(c[1]);
    s.z = 24'(c[2]);
    s.r = 20'(r);
    return s;
  endfunction

  task automatic write_reg(sioc_pkg::cfg_idx_e idx, longint value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= sioc_pkg::CfgDataBits'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      sioc_pkg::CFG_PERIODIC: periodic   = value[0];
      sioc_pkg::CFG_LEN_X:    dom_len[0] = value & COORD_MAX;
      sioc_pkg::CFG_LEN_Y:    dom_len[1] = value & COORD_MAX;
      sioc_pkg::CFG_LEN_Z:    dom_len[2] = value & COORD_MAX;
      sioc_pkg::CFG_PAD:      pad_len    = value & RAD_MAX;
      sioc_pkg::CFG_SEP:      sep_len    = value & RAD_MAX;
      default: ;
    endcase
  endtask

  task automatic set_mode(bit per, longint lx, longint ly, longint lz, longint pad,
                          longint sep);
    write_reg(sioc_pkg::CFG_PERIODIC, per);
    write_reg(sioc_pkg::CFG_LEN_X, lx);
    write_reg(sioc_pkg::CFG_LEN_Y, ly);
    write_reg(sioc_pkg::CFG_LEN_Z, lz);
    write_reg(sioc_pkg::CFG_PAD, pad);
    write_reg(sioc_pkg::CFG_SEP, sep);
  endtask

  task automatic offer(longint x, longint y, longint z, longint r);
    sphere_t s;
    s.x = 24'(x);
    s.y = 24'(y);
    s.z = 24'(z);
    s.r = 20'(r);
    add_proposal(s);
  endtask

  task automatic offer_random(int n);
    for (int k = 0; k < n; k++) begin
      while (proposals.size() != 0) @(posedge clk_i);
      add_proposal(draw_sphere());
    end
  endtask

  task automatic drain();
    while (proposals.size() != 0 || verdicts.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // input driver
  int  gap_left;
  int  sent_count;
  bit  quiet_in;
  always @(posedge clk_i or negedge rst_ni) begin : drive_proposals
    int      gap_next;
    sphere_t s;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      center_x_i      <= '0;
      center_y_i      <= '0;
      center_z_i      <= '0;
      sphere_radius_i <= '0;
      gap_left        <= 0;
      sent_count      <= 0;
      quiet_in        <= 1'b0;
    end else if (!(in_valid_i && in_stall_o)) begin
      gap_next = gap_left;
      if (in_valid_i) begin
        s.x = center_x_i;
        s.y = center_y_i;
        s.z = center_z_i;
        s.r = sphere_radius_i;
        add_verdict(judge_sphere(s));
        sent_count <= sent_count + 1;
        if (sent_count % 32 == 0) quiet_in <= ($urandom_range(0, 3) == 0);
        gap_next = quiet_in ? 0 : $urandom_range(0, 11);
      end
      if (gap_next != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_next - 1;
      end else if (proposals.size() != 0) begin
        s = proposals.pop_front();
        in_valid_i      <= 1'b1;
        center_x_i      <= s.x;
        center_y_i      <= s.y;
        center_z_i      <= s.z;
        sphere_radius_i <= s.r;
        gap_left        <= 0;
      end else begin
        in_valid_i <= 1'b0;
        gap_left   <= 0;
      end
    end
  end

  // result monitor
  int stall_left;
  int got_count;
  bit quiet_out;
  always @(posedge clk_i or negedge rst_ni) begin : check_verdicts
    int       n;
    verdict_t v;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      got_count   <= 0;
      quiet_out   <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      if (verdicts.size() == 0) begin
        errors++;
        if (errors <= MAX_ERRS) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        v = verdicts.pop_front();
        if (accepted_o !== v.acc || outcome_o !== v.oc || stored_index_o !== v.idx ||
            sphere_total_o !== v.tot || reject_streak_o !== v.streak) begin
          errors++;
          if (errors <= MAX_ERRS)
            $display("result %0d: exp acc=%0d oc=%0d idx=%0d tot=%0d streak=%0d, got acc=%0d oc=%0d idx=%0d tot=%0d streak=%0d",
                     got_count, v.acc, v.oc, v.idx, v.tot, v.streak, accepted_o,
                     outcome_o, stored_index_o, sphere_total_o, reject_streak_o);
        end
      end
      got_count <= got_count + 1;
      if (got_count % 32 == 0) quiet_out <= ($urandom_range(0, 3) == 0);
      n = quiet_out ? 0 : $urandom_range(0, 11);
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= LIMIT) begin
      $display("** sphere_insertion_overlap_checker_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors       = 0;
    idle_cycles  = 0;
    periodic     = 1'b0;
    dom_len[0]   = COORD_MAX;
    dom_len[1]   = COORD_MAX;
    dom_len[2]   = COORD_MAX;
    pad_len      = 0;
    sep_len      = 0;
    packed_count = 0;
    streak_run   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0);
    offer(0, 0, 0, 0);
    offer(COORD_MAX, COORD_MAX, COORD_MAX, 0);
    offer(0, 0, 0, 0);
    offer(24'h800000, 24'h800000, 24'h800000, RAD_MAX);
    offer(24'h800000 + 2 * RAD_MAX, 24'h800000, 24'h800000, RAD_MAX);
    offer(24'h800000 + 2 * RAD_MAX - 1, 24'h800000, 24'h800000, RAD_MAX);
    offer(RAD_MAX - 1, 24'h400000, 24'h400000, RAD_MAX);
    offer(RAD_MAX, COORD_MAX - RAD_MAX, 24'h200000, RAD_MAX);
    offer(24'h300000, COORD_MAX - RAD_MAX + 1, 24'h300000, RAD_MAX);
    offer(24'h555555, 24'hAAAAAA, 24'h555555, 20'hAAAAA);
    drain();
    offer_random(100);
    drain();

    set_mode(1, 1000, 2000, 1, RAD_MAX, 0);
    offer(COORD_MAX, COORD_MAX, COORD_MAX, 3);
    offer(100, 100, 0, 10);
    offer(600, 100, 0, 0);
    offer(1000, 1000, 0, 0);
    offer(400, 1500, 0, 1);
    drain();
    offer_random(100);
    drain();

    set_mode(0, 300000, 400000, 500000, 1000, 200);
    offer_random(110);
    drain();

    set_mode(0, 1, 1, 1, RAD_MAX, RAD_MAX);
    offer(0, 0, 0, 0);
    offer(1, 1, 1, 0);
    offer_random(30);
    drain();

    set_mode(1, COORD_MAX, COORD_MAX, 12345, 0, RAD_MAX);
    offer_random(100);
    drain();

    set_mode(0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 3);
    offer_random(110);
    drain();

    repeat (NSLOT + 16) @(posedge clk_i);
    if (errors == 0 && verdicts.size() == 0) begin
      $display("** sphere_insertion_overlap_checker_top: PASSED **");
    end else begin
      $display("** sphere_insertion_overlap_checker_top: FAILED **");
    end
    $finish;
  end

endmodule
